/* src/pctw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctw_pkg: shared types and constants of the prefix code tree walk decoder
// node table entry layout, command codes and default sizes
// ----------------------------------------------------------------------------
package pctw_pkg;

	// index width of the node fields and of the root register
	localparam int unsigned IDX_W = 9;
	localparam int unsigned SYM_W = 8;
	localparam int unsigned NODE_DEPTH_DEF = 512;

	// command codes of an input transaction
	localparam logic CMD_NODE_WRITE = 1'b0;
	localparam logic CMD_DECODE     = 1'b1;

	// one node table entry
	typedef struct packed {
		logic             leaf;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [SYM_W-1:0] sym;
	} node_t;

	localparam int unsigned NODE_W = $bits(node_t);

endpackage
`default_nettype wire

/* src/pctw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctw_ram: generic single-write single-read ram
// one write port, one read port with registered read data held between reads
// ----------------------------------------------------------------------------
module pctw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/prefix_code_tree_walk_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_code_tree_walk_decoder_top: huffman decoder walking a stored code tree
// node writes fill the tree table, decode transactions walk it one bit a step
// ----------------------------------------------------------------------------
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | cmd, node_index, node_is_leaf, left_child,
//          |                      | right_child, leaf_symbol, coded_byte,
//          |                      | valid_bits, message_end
// out      | out_valid / out_ready| symbol, last_of_run, message_done
// cfg      | cfg_we (no wait)     | cfg_wdata (root_index)
//
// a node write leaves in_ready high behind it
// a decode transaction walks the code bits of its byte in order: the single read port of
//   the node table gives one tree step per cycle while the output register does not stall,
//   and each symbol followed by more code bits costs one extra read to fetch the root
// a full output register stalls the walk whenever a held symbol has to move out
// reset clears the walk position and root register to zero; the table is not cleared
// in_ready is low while a decode transaction is in progress
//
module prefix_code_tree_walk_decoder_top #(
	parameter int unsigned NODE_DEPTH = pctw_pkg::NODE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_we,
	input  wire logic [pctw_pkg::IDX_W-1:0]  cfg_wdata,
	// input channel
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic                        cmd,
	input  wire logic [pctw_pkg::IDX_W-1:0]  node_index,
	input  wire logic                        node_is_leaf,
	input  wire logic [pctw_pkg::IDX_W-1:0]  left_child,
	input  wire logic [pctw_pkg::IDX_W-1:0]  right_child,
	input  wire logic [pctw_pkg::SYM_W-1:0]  leaf_symbol,
	input  wire logic [7:0]                  coded_byte,
	input  wire logic [3:0]                  valid_bits,
	input  wire logic                        message_end,
	// output channel
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [pctw_pkg::SYM_W-1:0]  symbol,
	output      logic                        last_of_run,
	output      logic                        message_done
);

	localparam int unsigned AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_NODE  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t                        state_q, state_d;
	logic [pctw_pkg::IDX_W-1:0]    root_q;
	logic [pctw_pkg::IDX_W-1:0]    walk_pos_q, walk_pos_d;
	logic [7:0]                    byte_q, byte_d;
	logic [3:0]                    nbits_q, nbits_d;
	logic [3:0]                    bit_cnt_q, bit_cnt_d;
	logic                          end_q, end_d;
	logic                          stepped_q, stepped_d;
	logic                          oob_q;
	logic                          pend_valid_q, pend_valid_d;
	logic [pctw_pkg::SYM_W-1:0]    pend_sym_q, pend_sym_d;
	logic                          out_valid_q, out_valid_d;
	logic [pctw_pkg::SYM_W-1:0]    out_sym_q, out_sym_d;
	logic                          out_last_q, out_last_d;
	logic                          out_done_q, out_done_d;

	// node table port signals
	logic                          ram_we;
	logic                          ram_re;
	logic [pctw_pkg::IDX_W-1:0]    rd_idx;
	logic [pctw_pkg::NODE_W-1:0]   ram_rdata;
	pctw_pkg::node_t               wr_node;
	pctw_pkg::node_t               node_rd;

	logic                          in_fire;
	logic                          out_free;
	logic                          bits_left;
	logic                          cur_bit;
	logic [pctw_pkg::IDX_W-1:0]    child;
	logic                          leaf_hit;
	logic                          need_push;
	logic                          wr_in_range;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// node writes outside the table are dropped
	assign wr_in_range = (32'(node_index) < NODE_DEPTH);
	assign ram_we      = in_fire && (cmd == pctw_pkg::CMD_NODE_WRITE) && wr_in_range;

	always_comb begin
		wr_node       = '0;
		wr_node.leaf  = node_is_leaf;
		wr_node.left  = left_child;
		wr_node.right = right_child;
		wr_node.sym   = leaf_symbol;
	end

	pctw_ram #(
		.WIDTH (pctw_pkg::NODE_W),
		.DEPTH (NODE_DEPTH)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(node_index)),
		.wdata (wr_node),
		.re    (ram_re),
		.raddr (AW'(rd_idx)),
		.rdata (ram_rdata)
	);

	// a step beyond the table sees an all-zero inner node
	assign node_rd   = oob_q ? '0 : pctw_pkg::node_t'(ram_rdata);

	// shared step unit: select child from the current node by the next code bit
	assign bits_left = (bit_cnt_q < nbits_q);
	assign cur_bit   = byte_q[7];
	assign child     = cur_bit ? node_rd.right : node_rd.left;
	assign leaf_hit  = stepped_q && node_rd.leaf;
	// a new symbol pushes the held one out, which needs room in the output register
	assign need_push = leaf_hit && pend_valid_q;

	always_comb begin
		state_d      = state_q;
		walk_pos_d   = walk_pos_q;
		byte_d       = byte_q;
		nbits_d      = nbits_q;
		bit_cnt_d    = bit_cnt_q;
		end_d        = end_q;
		stepped_d    = stepped_q;
		pend_valid_d = pend_valid_q;
		pend_sym_d   = pend_sym_q;
		out_valid_d  = out_valid_q && !out_ready;
		out_sym_d    = out_sym_q;
		out_last_d   = out_last_q;
		out_done_d   = out_done_q;
		ram_re       = 1'b0;
		rd_idx       = walk_pos_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_fire && (cmd == pctw_pkg::CMD_DECODE)) begin
					byte_d    = coded_byte;
					nbits_d   = valid_bits[3] ? 4'd8 : valid_bits;
					bit_cnt_d = '0;
					end_d     = message_end;
					stepped_d = 1'b0;
					if (valid_bits == 4'd0) begin
						state_d = S_FLUSH;
					end else begin
						// fetch the node the walk currently stands on
						ram_re  = 1'b1;
						rd_idx  = walk_pos_q;
						state_d = S_NODE;
					end
				end
			end
			S_NODE: begin
				if (leaf_hit) begin
					if (!need_push || out_free) begin
						if (need_push) begin
							out_valid_d = 1'b1;
							out_sym_d   = pend_sym_q;
							out_last_d  = 1'b0;
							out_done_d  = 1'b0;
						end
						pend_valid_d = 1'b1;
						pend_sym_d   = node_rd.sym;
						walk_pos_d   = root_q;
						stepped_d    = 1'b0;
						if (bits_left) begin
							// back to the root for the next code
							ram_re = 1'b1;
							rd_idx = root_q;
						end else begin
							state_d = S_FLUSH;
						end
					end
				end else if (bits_left) begin
					ram_re     = 1'b1;
					rd_idx     = child;
					walk_pos_d = child;
					stepped_d  = 1'b1;
					bit_cnt_d  = bit_cnt_q + 4'd1;
					byte_d     = {byte_q[6:0], 1'b0};
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					if (pend_valid_q) begin
						out_valid_d = 1'b1;
						out_sym_d   = pend_sym_q;
						out_last_d  = 1'b1;
						out_done_d  = end_q;
					end
					pend_valid_d = 1'b0;
					// message end drops any partly walked code
					if (end_q) begin
						walk_pos_d = root_q;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// root write moves the walk to the new root; the user writes it only while idle, the block does not enforce it
		if (cfg_we) begin
			walk_pos_d = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			root_q       <= '0;
			walk_pos_q   <= '0;
			byte_q       <= '0;
			nbits_q      <= '0;
			bit_cnt_q    <= '0;
			end_q        <= 1'b0;
			stepped_q    <= 1'b0;
			oob_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_sym_q   <= '0;
			out_valid_q  <= 1'b0;
			out_sym_q    <= '0;
			out_last_q   <= 1'b0;
			out_done_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			walk_pos_q   <= walk_pos_d;
			byte_q       <= byte_d;
			nbits_q      <= nbits_d;
			bit_cnt_q    <= bit_cnt_d;
			end_q        <= end_d;
			stepped_q    <= stepped_d;
			pend_valid_q <= pend_valid_d;
			pend_sym_q   <= pend_sym_d;
			out_valid_q  <= out_valid_d;
			out_sym_q    <= out_sym_d;
			out_last_q   <= out_last_d;
			out_done_q   <= out_done_d;
			if (cfg_we) begin
				root_q <= cfg_wdata;
			end
			// out-of-table flag travels with the registered read data
			if (ram_re) begin
				oob_q <= !(32'(rd_idx) < NODE_DEPTH);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol       = out_sym_q;
	assign last_of_run  = out_last_q;
	assign message_done = out_done_q;

	// no symbol is left held once the block takes a new transaction
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("symbol still held while idle");

	// the walk never uses more bits than the transaction carries
	a_bit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= nbits_q)
		else $error("bit counter ran past the valid bits");

	// table writes only happen while no walk reads it
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE))
		else $error("node write during a walk");

	// a new result appears only from the walk or the flush step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_NODE || $past(state_q) == S_FLUSH))
		else $error("result produced outside the walk");

	// the last symbol of a byte leaves from the flush step and flags message end faithfully
	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q && !$stable(out_sym_q)) |->
			($past(state_q) == S_FLUSH && out_done_q == $past(end_q)))
		else $error("last-of-run result not from flush");

endmodule
`default_nettype wire
